// ----- hw/rtl/token_class_recognizer_assert.svh -----
// Assertion macros used by the token class recognizer controller (tcr_ctrl).
`ifndef TOKEN_CLASS_RECOGNIZER_ASSERT_SVH
`define TOKEN_CLASS_RECOGNIZER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define TCR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("token_class_recognizer: assertion failed");

// Next-cycle implication.
`define TCR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("token_class_recognizer: assertion failed");

`else

`define TCR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define TCR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- hw/rtl/tcr_pkg.sv -----
package tcr_pkg;

    localparam int RSV_NUM     = 16;
    localparam int RSV_MAX_LEN = 7;
    localparam int CHAR_W      = 8;
    localparam int LEN_W       = 4;
    localparam logic [LEN_W-1:0] LEN_SAT = 4'd15;

    typedef logic [CHAR_W-1:0]  t_char;
    typedef logic [LEN_W-1:0]   t_len;
    typedef logic [RSV_NUM-1:0] t_rsv_vec;

    typedef enum logic [2:0] {
        CLS_ERROR    = 3'd0,
        CLS_IDENT    = 3'd1,
        CLS_RESERVED = 3'd2,
        CLS_INT      = 3'd3,
        CLS_SIGN     = 3'd4,
        CLS_POINT    = 3'd5,
        CLS_FLOAT    = 3'd6
    } t_cls;

    // Per-cycle command from the controller to every cell.
    typedef struct packed {
        logic adv;      // a character was taken
        logic restart;  // the token ends with this item
    } t_cell_ctl;

    localparam t_len RSV_LEN [RSV_NUM] = '{
        4'd5, 4'd3, 4'd6, 4'd5, 4'd2, 4'd4, 4'd6, 4'd4,
        4'd7, 4'd3, 4'd5, 4'd2, 4'd6, 4'd4, 4'd4, 4'd6
    };

    localparam t_char RSV_TEXT [RSV_NUM][RSV_MAX_LEN] = '{
        '{"c", "o", "n", "s", "t", 8'h00, 8'h00},
        '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"d", "o", "u", "b", "l", "e", 8'h00},
        '{"f", "l", "o", "a", "t", 8'h00, 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00},
        '{"s", "w", "i", "t", "c", "h", 8'h00},
        '{"c", "a", "s", "e", 8'h00, 8'h00, 8'h00},
        '{"d", "e", "f", "a", "u", "l", "t"},
        '{"f", "o", "r", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"w", "h", "i", "l", "e", 8'h00, 8'h00},
        '{"d", "o", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"s", "t", "r", "i", "n", "g", 8'h00},
        '{"c", "h", "a", "r", 8'h00, 8'h00, 8'h00},
        '{"l", "i", "s", "t", 8'h00, 8'h00, 8'h00},
        '{"v", "e", "c", "t", "o", "r", 8'h00}
    };

    // Character of a reserved word at a position, zero past the table.
    function automatic t_char rsv_char(input int w, input int pos);
        if (pos < RSV_MAX_LEN) begin
            return RSV_TEXT[w][pos];
        end
        return '0;
    endfunction

endpackage

// ----- hw/rtl/tcr_cell.sv -----
module tcr_cell #(
    parameter int IDX = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tcr_pkg::t_cell_ctl i_ctl,
    input  tcr_pkg::t_char     i_char,
    input  logic               i_tok,
    output logic               o_tok,
    input  tcr_pkg::t_rsv_vec  i_match,
    output tcr_pkg::t_rsv_vec  o_match
);
    import tcr_pkg::*;

    logic  r_tok;
    logic  n_tok;
    t_char r_char;
    t_char w_char;

    // The cell holding the write token is the one at the current position.
    always_comb begin
        n_tok = r_tok;
        if (i_ctl.restart) begin
            n_tok = 1'(IDX == 0);
        end else if (i_ctl.adv) begin
            n_tok = i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'(IDX == 0);
        end else begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv && r_tok) begin
            r_char <= i_char;
        end
    end

    assign w_char = r_tok ? i_char : r_char;
    assign o_tok  = r_tok;

    // Narrow the candidate set by this position's character.
    always_comb begin
        for (int w = 0; w < RSV_NUM; w++) begin
            if (IDX < int'(RSV_LEN[w])) begin
                o_match[w] = i_match[w] & (w_char == rsv_char(w, IDX));
            end else begin
                o_match[w] = i_match[w];
            end
        end
    end

endmodule

// ----- hw/rtl/tcr_ctrl.sv -----
`include "token_class_recognizer_assert.svh"

module tcr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  tcr_pkg::t_char     i_char,
    input  logic               i_last,
    input  logic               i_empty,
    output logic               o_valid,
    input  logic               i_stall,
    output tcr_pkg::t_cls      o_cls,
    output tcr_pkg::t_cell_ctl o_ctl,
    input  tcr_pkg::t_rsv_vec  i_match
);
    import tcr_pkg::*;

    typedef enum logic [6:0] {
        ST_START = 7'b0000001,
        ST_SIGN  = 7'b0000010,
        ST_INT   = 7'b0000100,
        ST_POINT = 7'b0001000,
        ST_FLOAT = 7'b0010000,
        ST_IDENT = 7'b0100000,
        ST_ERROR = 7'b1000000
    } t_scan;

    t_scan    r_state;
    t_scan    n_state;
    t_scan    w_step;
    t_len     r_len;
    t_len     n_len;
    t_len     w_len_inc;
    logic     r_valid;
    logic     n_valid;
    t_cls     r_cls;
    t_cls     n_cls;
    t_cls     w_final;
    t_rsv_vec w_len_hit;
    logic     w_reserved;
    logic     w_accept;
    logic     w_end;

    assign o_stall  = r_valid & i_stall;
    assign w_accept = i_valid & ~o_stall;
    assign w_end    = i_last | i_empty;

    assign o_ctl.adv     = w_accept & ~i_empty;
    assign o_ctl.restart = w_accept & w_end;

    assign w_len_inc = (r_len != LEN_SAT) ? r_len + t_len'(1) : r_len;

    always_comb begin
        w_step = ST_ERROR;
        case (i_char) inside
            ["0":"9"]: begin
                case (r_state)
                    ST_START, ST_SIGN, ST_INT: w_step = ST_INT;
                    ST_POINT, ST_FLOAT:        w_step = ST_FLOAT;
                    ST_IDENT:                  w_step = ST_IDENT;
                    default:                   w_step = ST_ERROR;
                endcase
            end
            ["a":"z"]: begin
                case (r_state)
                    ST_START, ST_IDENT: w_step = ST_IDENT;
                    default:            w_step = ST_ERROR;
                endcase
            end
            ".": begin
                w_step = (r_state == ST_INT) ? ST_POINT : ST_ERROR;
            end
            "+", "-": begin
                w_step = (r_state == ST_START) ? ST_SIGN : ST_ERROR;
            end
            default: begin
                w_step = ST_ERROR;
            end
        endcase
    end

    always_comb begin
        for (int w = 0; w < RSV_NUM; w++) begin
            w_len_hit[w] = (w_len_inc == RSV_LEN[w]);
        end
    end

    assign w_reserved = |(i_match & w_len_hit);

    always_comb begin
        case (w_step)
            ST_IDENT: w_final = w_reserved ? CLS_RESERVED : CLS_IDENT;
            ST_INT:   w_final = CLS_INT;
            ST_SIGN:  w_final = CLS_SIGN;
            ST_POINT: w_final = CLS_POINT;
            ST_FLOAT: w_final = CLS_FLOAT;
            default:  w_final = CLS_ERROR;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_len   = r_len;
        n_valid = r_valid & i_stall;
        n_cls   = r_cls;
        if (w_accept) begin
            if (w_end) begin
                n_state = ST_START;
                n_len   = '0;
                n_valid = 1'b1;
                n_cls   = i_empty ? CLS_ERROR : w_final;
            end else begin
                n_state = w_step;
                n_len   = w_len_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_START;
            r_len   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cls <= n_cls;
    end

    assign o_valid = r_valid;
    assign o_cls   = r_cls;

    `TCR_ASSERT_NEXT(a_end_restarts, i_clk, i_rst_n, w_accept && w_end, r_state == ST_START && r_len == '0)
    `TCR_ASSERT_NEXT(a_error_sticks, i_clk, i_rst_n, w_accept && !w_end && r_state == ST_ERROR, r_state == ST_ERROR)
    `TCR_ASSERT_IMPL(a_rsv_len, i_clk, i_rst_n, w_accept && !i_empty && w_final == CLS_RESERVED, w_len_inc >= 4'd2 && w_len_inc <= 4'd7)
    `TCR_ASSERT_NEXT(a_mid_no_result, i_clk, i_rst_n, w_accept && !w_end, r_valid == $past(r_valid && i_stall))

endmodule

// ----- hw/rtl/token_class_recognizer.sv -----
// Channel  Valid     Stall     Payload
// input    i_valid   o_stall   i_char_code, i_last_char, i_empty_token
// output   o_valid   i_stall   o_token_class
//
// One item per cycle, back to back, while o_stall is low; the class appears in the cycle after the
// last (or empty) item, from the output register.
// The character cells compare in parallel, so the token length does not set the rate.
// Reset (i_rst_n low, synchronous) puts the scanner in its start state with
// an empty word and no result pending.
// o_stall rises only while a result waits and i_stall is high.
module token_class_recognizer #(
    parameter int MAX_WORD_LEN = 7
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_char_code,
    input  logic       i_last_char,
    input  logic       i_empty_token,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_token_class
);
    import tcr_pkg::*;

    t_cell_ctl               w_ctl;
    t_cls                    w_cls;
    logic [MAX_WORD_LEN:0]   w_tok;
    t_rsv_vec                w_match [MAX_WORD_LEN+1];

    assign w_tok[0]   = 1'b0;
    assign w_match[0] = '1;

    for (genvar g = 0; g < MAX_WORD_LEN; g++) begin : g_cell
        tcr_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_char  (i_char_code),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1]),
            .i_match (w_match[g]),
            .o_match (w_match[g+1])
        );
    end

    tcr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_char  (i_char_code),
        .i_last  (i_last_char),
        .i_empty (i_empty_token),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cls   (w_cls),
        .o_ctl   (w_ctl),
        .i_match (w_match[MAX_WORD_LEN])
    );

    assign o_token_class = 3'(w_cls);

endmodule
